### rtl/rpeq_pkg.sv
// Shared types, constants and the summary merge function for the range
// prefix excursion query block. No dependencies.
`timescale 1ns / 1ps

package rpeq_pkg;

  localparam int MAX_LEN    = 1024;
  localparam int LEAF_BITS  = $clog2(MAX_LEN);
  localparam int NODE_BITS  = LEAF_BITS + 1;
  localparam int NODE_COUNT = 2 * MAX_LEN;
  localparam int POS_W      = 11;
  localparam int VAL_W      = 31;
  localparam int DIFF_W     = VAL_W + 1;
  localparam int EXC_W      = 42;
  localparam int NET_W      = 43;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [EXC_W-1:0]        rise;
    logic [EXC_W-1:0]        fall;
    logic signed [NET_W-1:0] net;
  } summary_t;

  typedef struct packed {
    logic             cmd;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] first_value;
    logic [VAL_W-1:0] second_value;
    logic [POS_W-1:0] range_start;
    logic [POS_W-1:0] range_end;
  } req_word_t;

  typedef struct packed {
    logic [EXC_W-1:0] answer;
    logic             impossible;
  } rsp_word_t;

  // Classified job: for a load, lo is the leaf node; for a query, lo/hi are
  // the leaf nodes bounding the range (lo > hi means empty).
  typedef struct packed {
    logic                 is_query;
    logic [NODE_BITS-1:0] lo;
    logic [NODE_BITS-1:0] hi;
    summary_t             leaf;
  } job_t;

  function automatic summary_t combine(summary_t a, summary_t b);
    logic signed [NET_W:0] up;
    logic signed [NET_W:0] down;
    summary_t r;
    up   = (NET_W+1)'(a.net) + $signed({2'b00, b.rise});
    down = $signed({2'b00, b.fall}) - (NET_W+1)'(a.net);
    r.rise = ($signed({2'b00, a.rise}) > up) ? a.rise : up[EXC_W-1:0];
    r.fall = ($signed({2'b00, a.fall}) > down) ? a.fall : down[EXC_W-1:0];
    r.net  = a.net + b.net;
    return r;
  endfunction

endpackage

### rtl/rpeq_ifs.sv
// Handshake channels of the range prefix excursion query block.
// Depends on rpeq_pkg.
`timescale 1ns / 1ps

interface rpeq_req_if;
  logic                 valid;
  logic                 ready;
  rpeq_pkg::req_word_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface rpeq_rsp_if;
  logic                 valid;
  logic                 ready;
  rpeq_pkg::rsp_word_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/rpeq_front.sv
// Front end: accepts request words, clamps query bounds, drops out-of-range
// loads and builds leaf summaries. Depends on rpeq_pkg, rpeq_ifs.
`timescale 1ns / 1ps

module rpeq_front (
  rpeq_req_if.sink        req,
  input  logic            full,
  output logic            push,
  output rpeq_pkg::job_t  job
);
  import rpeq_pkg::*;

  logic [POS_W-1:0]         lo_c;
  logic [POS_W-1:0]         hi_c;
  logic signed [DIFF_W-1:0] diff;
  logic                     keep;

  always_comb begin
    lo_c = (req.payload.range_start == '0) ? POS_W'(1) : req.payload.range_start;
    hi_c = (req.payload.range_end > POS_W'(MAX_LEN)) ? POS_W'(MAX_LEN)
                                                     : req.payload.range_end;
    diff = $signed({1'b0, req.payload.first_value})
         - $signed({1'b0, req.payload.second_value});

    job.is_query = (req.payload.cmd == CMD_QUERY);
    job.leaf.rise = (diff > 0) ? EXC_W'(diff) : '0;
    job.leaf.fall = (diff < 0) ? EXC_W'(-diff) : '0;
    job.leaf.net  = NET_W'(diff);
    if (req.payload.cmd == CMD_QUERY) begin
      keep = 1'b1;
      if (lo_c > hi_c) begin
        // empty range: bounds that end the walk at once
        job.lo = NODE_BITS'(1);
        job.hi = '0;
      end else begin
        job.lo = NODE_BITS'(lo_c + POS_W'(MAX_LEN - 1));
        job.hi = NODE_BITS'(hi_c + POS_W'(MAX_LEN - 1));
      end
    end else begin
      keep   = (req.payload.position != '0) &&
               (req.payload.position <= POS_W'(MAX_LEN));
      job.lo = NODE_BITS'(req.payload.position + POS_W'(MAX_LEN - 1));
      job.hi = '0;
    end
  end

  assign req.ready = !full;
  assign push      = req.valid && !full && keep;

endmodule

### rtl/rpeq_queue.sv
// Two-entry job queue between front and back end. Depends on rpeq_pkg.
`timescale 1ns / 1ps

module rpeq_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rpeq_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            avail,
  output rpeq_pkg::job_t  head
);
  import rpeq_pkg::*;

  job_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= push_job;
        wr_ptr       <= !wr_ptr;
      end
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = slot[rd_ptr];

endmodule

### rtl/rpeq_back.sv
// Back end: node store, clearing pass, leaf-to-root update walk and
// bottom-up range query walk, plus the response register.
// Depends on rpeq_pkg, rpeq_ifs.
`timescale 1ns / 1ps

module rpeq_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  input  rpeq_pkg::job_t  job,
  output logic            job_ready,
  rpeq_rsp_if.source      rsp
);
  import rpeq_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LREAD, S_LMERGE, S_QREAD, S_QMERGE, S_QFIN
  } state_t;

  state_t               state;
  logic [NODE_BITS-1:0] clr_cnt;
  logic [NODE_BITS-1:0] k;
  logic [NODE_BITS-1:0] l;
  logic [NODE_BITS-1:0] r;
  logic [NODE_BITS-1:0] l_next;
  logic [NODE_BITS-1:0] r_next;
  logic                 take_l;
  logic                 take_r;
  summary_t             accl;
  summary_t             accr;
  logic                 rsp_valid;
  rsp_word_t            rsp_data;
  logic                 rsp_load;

  summary_t             mem [NODE_COUNT];
  summary_t             rd_a;
  summary_t             rd_b;
  logic                 we;
  logic [NODE_BITS-1:0] wa;
  summary_t             wd;
  logic [NODE_BITS-1:0] ra_a;
  logic [NODE_BITS-1:0] ra_b;

  summary_t             merged;
  summary_t             cl;
  summary_t             cr;
  summary_t             total;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_a <= mem[ra_a];
    rd_b <= mem[ra_b];
  end

  always_comb begin
    merged = combine(rd_a, rd_b);
    cl     = combine(accl, rd_a);
    cr     = combine(rd_b, accr);
    total  = combine(accl, accr);
    l_next = NODE_BITS'(((NODE_BITS+1)'(l) + (NODE_BITS+1)'(l[0])) >> 1);
    r_next = NODE_BITS'(r - NODE_BITS'(!r[0])) >> 1;
    we   = 1'b0;
    wa   = k;
    wd   = merged;
    ra_a = {k[NODE_BITS-2:0], 1'b0};
    ra_b = {k[NODE_BITS-2:0], 1'b1};
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr_cnt;
        wd = '0;
      end
      S_IDLE: begin
        we = job_valid && !job.is_query;
        wa = job.lo;
        wd = job.leaf;
      end
      S_LMERGE: we = 1'b1;
      S_QREAD: begin
        ra_a = l;
        ra_b = r;
      end
      default: ;
    endcase
  end

  // response register takes a new word when empty or draining this cycle
  assign rsp_load = (state == S_QFIN) && (!rsp_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) rsp_valid <= 1'b1;
      else if (rsp.ready) rsp_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == NODE_BITS'(NODE_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (job_valid) begin
            if (job.is_query) begin
              l     <= job.lo;
              r     <= job.hi;
              accl  <= '0;
              accr  <= '0;
              state <= S_QREAD;
            end else begin
              k     <= job.lo >> 1;
              state <= S_LREAD;
            end
          end
        end
        S_LREAD: state <= S_LMERGE;
        S_LMERGE: begin
          if (k == NODE_BITS'(1)) begin
            state <= S_IDLE;
          end else begin
            k     <= k >> 1;
            state <= S_LREAD;
          end
        end
        S_QREAD: begin
          if (l > r) begin
            state <= S_QFIN;
          end else begin
            take_l <= l[0];
            take_r <= !r[0];
            l      <= l_next;
            r      <= r_next;
            state  <= S_QMERGE;
          end
        end
        S_QMERGE: begin
          if (take_l) accl <= cl;
          if (take_r) accr <= cr;
          state <= S_QREAD;
        end
        S_QFIN: begin
          if (rsp_load) begin
            if (total.net == '0 && total.rise == '0) begin
              rsp_data.answer     <= total.fall;
              rsp_data.impossible <= 1'b0;
            end else begin
              rsp_data.answer     <= '0;
              rsp_data.impossible <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign job_ready   = (state == S_IDLE);
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_data;

`ifndef SYNTHESIS
  a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !rsp_valid) else $error("response during clearing pass");
  a_root_stop: assert property (@(posedge clk) disable iff (rst)
    state == S_LMERGE |-> k != '0) else $error("update walk passed the root");
  a_query_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_QREAD || state == S_QMERGE || state == S_QFIN) |-> !we)
    else $error("store written during query");
  a_impossible_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.impossible |-> rsp_data.answer == '0)
    else $error("impossible response with nonzero answer");
`endif

endmodule

### rtl/range_prefix_excursion_query.sv
// Top level of the range prefix excursion query block: front end, job queue
// and back end. Depends on rpeq_pkg, rpeq_ifs and the rpeq_* modules.
`timescale 1ns / 1ps

// Keeps a segment tree over per-position differences (first - second) for
// positions 1..1024. A load word (cmd 0) writes one leaf and re-merges its
// path to the root; it gives no response and is dropped if its position is
// 0 or above 1024. A query word (cmd 1) merges the node summaries over
// [range_start, range_end] (start clamped up to 1, end down to 1024) and
// returns one response: the greatest fall of the running sum, or impossible
// when the range net is nonzero or the sum ever rises. After reset a
// clearing pass zeroes every node of the store; request words are
// queued (two deep) but not served until it ends. The back end handles one
// job at a time, bound by the single node store: a load makes one leaf
// write, then a read and a merge-write for each of 10 levels; a query
// does a start step, then a read and a merge step per tree level visited
// (at most 11), then a final bound check and a finish. The front end and
// queue accept words while the back end is busy, and a finished response
// waits in its register while the next job runs; only the finish of the
// next query waits for it to drain.
module range_prefix_excursion_query (
  input  logic        clk,
  input  logic        rst,
  rpeq_req_if.sink    req,
  rpeq_rsp_if.source  rsp
);
  import rpeq_pkg::*;

  job_t front_job;
  job_t head_job;
  logic push;
  logic full;
  logic avail;
  logic job_ready;

  rpeq_front u_front (
    .req  (req),
    .full (full),
    .push (push),
    .job  (front_job)
  );

  rpeq_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (front_job),
    .full     (full),
    .pop      (avail && job_ready),
    .avail    (avail),
    .head     (head_job)
  );

  rpeq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (avail),
    .job       (head_job),
    .job_ready (job_ready),
    .rsp       (rsp)
  );

endmodule

### sim/rpeq_checker.sv
// Checker for the range prefix excursion query block: mirrors the segment
// tree, predicts each query response and compares it. Depends on rpeq_pkg, rpeq_ifs.
`timescale 1ns / 1ps

module rpeq_checker (
  input  logic     clk,
  input  logic     rst,
  rpeq_req_if      req,
  rpeq_rsp_if      rsp,
  output int       fail_count,
  output int       pending,
  output logic     accepted
);
  import rpeq_pkg::*;

  typedef struct {
    longint rise;
    longint fall;
    longint net;
  } excursion_t;

  excursion_t tree_node [2*MAX_LEN];
  rsp_word_t  answer_q [$];

  function automatic excursion_t merge_span(excursion_t l, excursion_t r);
    excursion_t m;
    longint up;
    longint down;
    up     = l.net + r.rise;
    down   = r.fall - l.net;
    m.rise = (l.rise > up) ? l.rise : up;
    m.fall = (l.fall > down) ? l.fall : down;
    m.net  = l.net + r.net;
    return m;
  endfunction

  // Leaf k of an implicit tree over [1, MAX_LEN]; MAX_LEN is a power of two
  // so the halving split matches node MAX_LEN + pos - 1.
  task automatic write_leaf(int pos, longint d);
    int k;
    k = MAX_LEN + pos - 1;
    tree_node[k].rise = (d > 0) ? d : 0;
    tree_node[k].fall = (d < 0) ? -d : 0;
    tree_node[k].net  = d;
    k = k / 2;
    while (k >= 1) begin
      tree_node[k] = merge_span(tree_node[2*k], tree_node[2*k+1]);
      k = k / 2;
    end
  endtask

  function automatic excursion_t span_of(int k, int s, int e, int lo, int hi);
    excursion_t acc;
    int m;
    acc = '{0, 0, 0};
    if (hi < s || e < lo) return acc;
    if (lo <= s && e <= hi) return tree_node[k];
    m = (s + e) / 2;
    if (lo <= m) acc = merge_span(acc, span_of(2*k, s, m, lo, hi));
    if (hi > m) acc = merge_span(acc, span_of(2*k+1, m+1, e, lo, hi));
    return acc;
  endfunction

  function automatic rsp_word_t predict_answer(int lo, int hi);
    excursion_t q;
    rsp_word_t w;
    if (lo < 1) lo = 1;
    if (hi > MAX_LEN) hi = MAX_LEN;
    q = (lo > hi) ? '{0, 0, 0} : span_of(1, 1, MAX_LEN, lo, hi);
    if (q.net == 0 && q.rise == 0) begin
      w.answer = q.fall[EXC_W-1:0];
      w.impossible = 1'b0;
    end else begin
      w.answer = '0;
      w.impossible = 1'b1;
    end
    return w;
  endfunction

  initial begin
    fail_count = 0;
    foreach (tree_node[i]) tree_node[i] = '{0, 0, 0};
  end

  assign pending  = answer_q.size();
  assign accepted = (req.valid && req.ready) || (rsp.valid && rsp.ready);

  always @(posedge clk) begin
    rsp_word_t exp_w;
    if (!rst) begin
      if (req.valid && req.ready) begin
        if (req.payload.cmd == CMD_LOAD) begin
          if (req.payload.position >= 1 && req.payload.position <= MAX_LEN)
            write_leaf(req.payload.position,
                       longint'(req.payload.first_value) -
                       longint'(req.payload.second_value));
        end else begin
          answer_q.push_back(predict_answer(req.payload.range_start,
                                            req.payload.range_end));
        end
      end
      if (rsp.valid && rsp.ready) begin
        if (answer_q.size() == 0) begin
          $error("unexpected response word answer=%0d", rsp.payload.answer);
          fail_count++;
        end else begin
          exp_w = answer_q.pop_front();
          if (rsp.payload.answer !== exp_w.answer) begin
            $error("answer: expected %0d, got %0d", exp_w.answer, rsp.payload.answer);
            fail_count++;
          end
          if (rsp.payload.impossible !== exp_w.impossible) begin
            $error("impossible: expected %0d, got %0d", exp_w.impossible,
                   rsp.payload.impossible);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

### sim/testbench.sv
// Top of the range prefix excursion query testbench: clock, reset, request
// stimulus, response back-pressure and verdict. Depends on rpeq_pkg, rpeq_ifs,
// rpeq_checker and the block.
`timescale 1ns / 1ps

module testbench;
  import rpeq_pkg::*;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  logic accepted;
  logic calm;        // last stretch of the run: no idling on either side
  logic stim_done;
  int   quiet_cycles;

  // Covers the clearing pass plus a full job and the longest stalls, with margin.
  localparam int QUIET_LIMIT = 20000;
  localparam int RANDOM_WORDS = 1130;

  rpeq_req_if req ();
  rpeq_rsp_if rsp ();

  range_prefix_excursion_query dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  rpeq_checker chk (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .fail_count(fail_count), .pending(pending), .accepted(accepted)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Narrow window of positions: keeps random loads and queries overlapping
  // so the running sums cancel and real answers come out, not just
  // impossible flags.
  int win_lo;

  function automatic req_word_t load_word(int pos, int a, int b);
    req_word_t w;
    w = '0;
    w.cmd = CMD_LOAD;
    w.position = pos[POS_W-1:0];
    w.first_value = a[VAL_W-1:0];
    w.second_value = b[VAL_W-1:0];
    // unused fields still carry noise, so every bit toggles
    w.range_start = POS_W'($urandom);
    w.range_end = POS_W'($urandom);
    return w;
  endfunction

  function automatic req_word_t query_word(int lo, int hi);
    req_word_t w;
    w = '0;
    w.cmd = CMD_QUERY;
    w.position = POS_W'($urandom);
    w.first_value = VAL_W'($urandom);
    w.second_value = VAL_W'($urandom);
    w.range_start = lo[POS_W-1:0];
    w.range_end = hi[POS_W-1:0];
    return w;
  endfunction

  // Send one word; bursty gaps before it unless in the calm stretch.
  task automatic send_word(req_word_t w);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.payload <= w;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random word: mostly small-valued loads near the window and queries over
  // it, so zero-net ranges happen; a few extreme or out-of-range items.
  function automatic req_word_t random_word();
    int pick;
    int lo;
    int hi;
    int v;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      v = $urandom_range(0, 6);
      return load_word(win_lo + $urandom_range(0, 7), v, $urandom_range(0, 6));
    end else if (pick < 80) begin
      lo = win_lo + $urandom_range(0, 7);
      hi = lo + $urandom_range(0, 7);
      return query_word(lo, hi);
    end else if (pick < 88) begin
      return load_word($urandom_range(0, 2047), $urandom, $urandom);
    end else if (pick < 95) begin
      lo = $urandom_range(0, 1100);
      return query_word(lo, lo + $urandom_range(0, 900));
    end else begin
      return query_word($urandom_range(0, 2047), $urandom_range(0, 2047));
    end
  endfunction

  initial begin
    req_word_t w;
    int lim;
    rst = 1'b1;
    calm = 1'b0;
    stim_done = 1'b0;
    req.valid = 1'b0;
    req.payload = '0;
    win_lo = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: fresh store, extremes, negative leaves, cancelling pairs,
    // clamped and empty ranges, dropped loads.
    send_word(query_word(1, 1024));
    send_word(load_word(1, 0, 2147483647));          // most negative leaf
    send_word(load_word(1024, 2147483647, 0));       // most positive leaf
    send_word(query_word(1, 1));
    send_word(query_word(1024, 1024));
    send_word(query_word(1, 1024));                  // net zero, no rise: real answer
    send_word(load_word(1024, 0, 0));
    send_word(load_word(2, 2147483647, 0));          // cancels position 1
    send_word(query_word(1, 2));
    send_word(query_word(0, 2047));                  // both bounds clamped
    send_word(query_word(5, 3));                     // empty range
    send_word(query_word(2047, 1500));               // empty after clamping
    send_word(load_word(0, 5, 1));                   // dropped
    send_word(load_word(1025, 5, 1));                // dropped
    send_word(load_word(2047, 7, 9));                // dropped
    send_word(query_word(1, 1024));
    send_word(load_word(512, 3, 8));
    send_word(load_word(513, 8, 3));
    send_word(query_word(512, 513));
    send_word(query_word(511, 514));
    send_word(query_word(513, 512));
    send_word(load_word(700, 12345, 12345));
    send_word(query_word(700, 700));

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 60 == 0) win_lo = $urandom_range(1, 1010);
      if (i == RANDOM_WORDS - 150) calm = 1'b1;
      w = random_word();
      send_word(w);
    end
    req.valid <= 1'b0;
    stim_done = 1'b1;

    lim = 0;
    while (pending != 0 && lim < QUIET_LIMIT) begin
      @(negedge clk);
      lim++;
    end
    repeat (60) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Response side: bursts of back-pressure, none in the calm stretch.
  initial begin
    int stall;
    rsp.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 19);
        rsp.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (rst || accepted || (stim_done && pending == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end
endmodule

### filelist.f
rtl/rpeq_pkg.sv
rtl/rpeq_ifs.sv
rtl/rpeq_front.sv
rtl/rpeq_queue.sv
rtl/rpeq_back.sv
rtl/range_prefix_excursion_query.sv
sim/rpeq_checker.sv
sim/testbench.sv
